// ----- rtl/fst_pkg.sv -----
`timescale 1ns / 1ps

package fst_pkg;

    localparam int unsigned MAX_FRAMES_DEF  = 64;
    localparam int unsigned MAX_ADVANCE_DEF = 64;

    localparam int unsigned CMD_W      = 3;
    localparam int unsigned TIME_W     = 24;
    localparam int unsigned FNUM_W     = 6;
    localparam int unsigned COUNT_W    = 7;
    localparam int unsigned SPEED_W    = 16;
    localparam int unsigned SPEED_FRAC = 8;
    localparam int unsigned ACC_W      = 32;
    localparam int unsigned PROG_W     = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam int unsigned SCALE_W = TIME_W + SPEED_W;
    localparam int unsigned MUL_W   = COUNT_W + TIME_W;
    localparam int unsigned REM_W   = ACC_W + 1;
    localparam int unsigned QCNT_W  = $clog2(PROG_W);

    localparam logic [TIME_W-1:0]  DEFAULT_DURATION = 24'd100000;
    localparam logic [SPEED_W-1:0] SPEED_RST        = 16'd256;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK      = 3'd0,
        CMD_PLAY      = 3'd1,
        CMD_PAUSE     = 3'd2,
        CMD_RESUME    = 3'd3,
        CMD_STOP      = 3'd4,
        CMD_SET_FRAME = 3'd5,
        CMD_LOAD_DUR  = 3'd6
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_COUNT = 2'd0,
        CFG_LOOP_ENABLE = 2'd1,
        CFG_SPEED       = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TADD,
        ST_TSTEP,
        ST_PRD,
        ST_PMUL,
        ST_PADD,
        ST_DCHK,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

// ----- rtl/frame_sequence_timer_unit.sv -----
`timescale 1ns / 1ps

// Channel  Direction  Handshake                    Payload
// in       input      i_in_valid / o_in_stall      i_cmd, i_delta_time, i_frame_number,
//                                                  i_duration_value
// out      output     o_out_valid / i_out_stall    o_frame_index, o_playing, o_paused,
//                                                  o_finished, o_progress
// cfg      input      i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// One word at a time. A tick on a running sequence adds the scaled time, then steps
// through k frame advances (at most MAX_ADVANCE), one per duration memory read, before
// the progress multiply, add and divide; other commands go straight to the progress steps.
// The progress divider is skipped when progress saturates or the frame count is zero.
// After reset a clearing pass loads the duration memory with the default duration; input is
// stalled meanwhile, configuration writes are taken. A waiting result does not block the
// next input word; a result is only held back while the previous one is still stalled.

module frame_sequence_timer_unit #(
    parameter int unsigned MAX_FRAMES  = fst_pkg::MAX_FRAMES_DEF,
    parameter int unsigned MAX_ADVANCE = fst_pkg::MAX_ADVANCE_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [fst_pkg::CMD_W-1:0]       i_cmd,
    input  logic [fst_pkg::TIME_W-1:0]      i_delta_time,
    input  logic [fst_pkg::FNUM_W-1:0]      i_frame_number,
    input  logic [fst_pkg::TIME_W-1:0]      i_duration_value,

    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [fst_pkg::FNUM_W-1:0]      o_frame_index,
    output logic                            o_playing,
    output logic                            o_paused,
    output logic                            o_finished,
    output logic [fst_pkg::PROG_W-1:0]      o_progress,

    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [fst_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fst_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    import fst_pkg::*;

    localparam int unsigned AW = $clog2(MAX_FRAMES);
    localparam int unsigned SW = $clog2(MAX_ADVANCE + 1);

    t_state r_state, n_state;

    logic [COUNT_W-1:0] r_frame_count, n_frame_count;
    logic               r_loop, n_loop;
    logic [SPEED_W-1:0] r_speed, n_speed;

    logic [COUNT_W-1:0] r_position, n_position;
    logic [ACC_W-1:0]   r_time, n_time;
    logic               r_run, n_run;
    logic               r_hold, n_hold;
    logic               r_done, n_done;

    logic [ACC_W-1:0]   r_scaled, n_scaled;
    logic [SW-1:0]      r_steps, n_steps;
    logic [MUL_W-1:0]   r_prod, n_prod;
    logic [MUL_W-1:0]   r_den, n_den;
    logic               r_dur_zero, n_dur_zero;
    logic [REM_W-1:0]   r_rem, n_rem;
    logic [PROG_W-1:0]  r_quo, n_quo;
    logic [QCNT_W-1:0]  r_qcnt, n_qcnt;
    logic [AW-1:0]      r_clr_cnt, n_clr_cnt;

    logic               r_out_valid;
    logic [FNUM_W-1:0]  r_out_frame;
    logic               r_out_playing;
    logic               r_out_paused;
    logic               r_out_finished;
    logic [PROG_W-1:0]  r_out_progress;

    logic [TIME_W-1:0]  r_mem [MAX_FRAMES];
    logic [TIME_W-1:0]  r_rd_data;

    logic               in_accept;
    logic               out_free;
    logic               out_load;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [TIME_W-1:0]  mem_wdata;
    logic [AW-1:0]      mem_raddr;

    logic [COUNT_W-1:0] eff_count;
    logic               tick_go;
    logic [SCALE_W-1:0] scale_full;
    logic [ACC_W:0]     time_sum;
    logic [ACC_W-1:0]   dur_ext;
    logic [COUNT_W-1:0] pos_inc;
    logic               step_go;
    logic               step_end;
    logic [REM_W-1:0]   den_ext;
    logic [REM_W-1:0]   rem_sh;
    logic               rem_ge;

    assign eff_count = (32'(r_frame_count) > MAX_FRAMES) ? COUNT_W'(MAX_FRAMES)
                                                         : r_frame_count;
    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign tick_go   = (t_cmd'(i_cmd) == CMD_TICK) && (eff_count != '0) && r_run && !r_hold
                       && !(r_done && !r_loop);

    assign scale_full = SCALE_W'(i_delta_time) * SCALE_W'(r_speed);
    assign time_sum   = {1'b0, r_time} + {1'b0, r_scaled};
    assign dur_ext    = ACC_W'(r_rd_data);
    assign pos_inc    = r_position + 1'b1;
    assign step_go    = (r_time >= dur_ext) && (r_steps < SW'(MAX_ADVANCE));
    assign step_end   = step_go && (pos_inc >= eff_count) && !r_loop;
    assign den_ext    = REM_W'(r_den);
    assign rem_sh     = {r_rem[REM_W-2:0], 1'b0};
    assign rem_ge     = rem_sh >= den_ext;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_cnt == AW'(MAX_FRAMES - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_accept) n_state = tick_go ? ST_TADD : ST_PRD;
            end
            ST_TADD:  n_state = ST_TSTEP;
            ST_TSTEP: begin
                if (!step_go || step_end) n_state = ST_PRD;
            end
            ST_PRD:   n_state = ST_PMUL;
            ST_PMUL:  n_state = ST_PADD;
            ST_PADD:  n_state = ST_DCHK;
            ST_DCHK: begin
                if (eff_count == '0 || r_rem >= den_ext) n_state = ST_DONE;
                else                                     n_state = ST_DIV;
            end
            ST_DIV: begin
                if (r_qcnt == QCNT_W'(PROG_W - 1)) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_in_stall  = (r_state != ST_IDLE);
        o_cfg_ready = 1'b1;
        out_load    = (r_state == ST_DONE) && out_free;
        mem_we      = 1'b0;
        mem_waddr   = AW'(i_frame_number);
        mem_wdata   = i_duration_value;
        if (r_state == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_cnt;
            mem_wdata = DEFAULT_DURATION;
        end else if (in_accept && t_cmd'(i_cmd) == CMD_LOAD_DUR
                     && 32'(i_frame_number) < MAX_FRAMES) begin
            mem_we = 1'b1;
        end
    end

    // datapath
    always_comb begin
        n_frame_count = r_frame_count;
        n_loop        = r_loop;
        n_speed       = r_speed;
        n_position    = r_position;
        n_time        = r_time;
        n_run         = r_run;
        n_hold        = r_hold;
        n_done        = r_done;
        n_scaled      = r_scaled;
        n_steps       = r_steps;
        n_prod        = r_prod;
        n_den         = r_den;
        n_dur_zero    = r_dur_zero;
        n_rem         = r_rem;
        n_quo         = r_quo;
        n_qcnt        = r_qcnt;
        n_clr_cnt     = r_clr_cnt;

        unique case (r_state)
            ST_CLEAR: n_clr_cnt = r_clr_cnt + 1'b1;
            ST_IDLE: begin
                if (in_accept) begin
                    n_scaled = scale_full[SCALE_W-1:SPEED_FRAC];
                    n_steps  = '0;
                    unique case (t_cmd'(i_cmd))
                        CMD_PLAY: begin
                            n_position = '0;
                            n_time     = '0;
                            n_done     = 1'b0;
                            n_run      = 1'b1;
                            n_hold     = 1'b0;
                        end
                        CMD_PAUSE: begin
                            if (r_run) begin
                                n_hold = 1'b1;
                                n_run  = 1'b0;
                            end
                        end
                        CMD_RESUME: begin
                            if (r_hold) begin
                                n_hold = 1'b0;
                                n_run  = 1'b1;
                            end
                        end
                        CMD_STOP: begin
                            n_position = '0;
                            n_time     = '0;
                            n_done     = 1'b0;
                            n_run      = 1'b0;
                            n_hold     = 1'b0;
                        end
                        CMD_SET_FRAME: begin
                            if (COUNT_W'(i_frame_number) < eff_count) begin
                                n_position = COUNT_W'(i_frame_number);
                                n_time     = '0;
                                n_done     = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_TADD: n_time = time_sum[ACC_W] ? '1 : time_sum[ACC_W-1:0];
            ST_TSTEP: begin
                if (step_go) begin
                    n_time  = r_time - dur_ext;
                    n_steps = r_steps + 1'b1;
                    if (pos_inc >= eff_count) begin
                        if (r_loop) begin
                            n_position = '0;
                        end else begin
                            n_position = eff_count - 1'b1;
                            n_done     = 1'b1;
                            n_run      = 1'b0;
                            n_time     = '0;
                        end
                    end else begin
                        n_position = pos_inc;
                    end
                end
            end
            ST_PRD: ;
            ST_PMUL: begin
                n_dur_zero = (r_rd_data == '0);
                if (r_rd_data == '0) begin
                    n_prod = MUL_W'(r_position);
                    n_den  = MUL_W'(eff_count);
                end else begin
                    n_prod = MUL_W'(r_position) * MUL_W'(r_rd_data);
                    n_den  = MUL_W'(r_rd_data) * MUL_W'(eff_count);
                end
            end
            ST_PADD: n_rem = r_dur_zero ? REM_W'(r_prod) : REM_W'(r_prod) + REM_W'(r_time);
            ST_DCHK: begin
                n_qcnt = '0;
                if (eff_count == '0)        n_quo = '0;
                else if (r_rem >= den_ext)  n_quo = '1;
                else                        n_quo = '0;
            end
            ST_DIV: begin
                n_rem  = rem_ge ? rem_sh - den_ext : rem_sh;
                n_quo  = {r_quo[PROG_W-2:0], rem_ge};
                n_qcnt = r_qcnt + 1'b1;
            end
            ST_DONE: ;
            default: ;
        endcase

        if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FRAME_COUNT: begin
                    n_frame_count = i_cfg_data[COUNT_W-1:0];
                    n_position    = '0;
                    n_time        = '0;
                    n_done        = 1'b0;
                end
                CFG_LOOP_ENABLE: n_loop  = i_cfg_data[0];
                CFG_SPEED:       n_speed = i_cfg_data[SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    assign mem_raddr = AW'(n_position);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLEAR;
            r_clr_cnt     <= '0;
            r_frame_count <= '0;
            r_loop        <= 1'b1;
            r_speed       <= SPEED_RST;
            r_position    <= '0;
            r_time        <= '0;
            r_run         <= 1'b0;
            r_hold        <= 1'b0;
            r_done        <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_clr_cnt     <= n_clr_cnt;
            r_frame_count <= n_frame_count;
            r_loop        <= n_loop;
            r_speed       <= n_speed;
            r_position    <= n_position;
            r_time        <= n_time;
            r_run         <= n_run;
            r_hold        <= n_hold;
            r_done        <= n_done;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_scaled   <= n_scaled;
        r_steps    <= n_steps;
        r_prod     <= n_prod;
        r_den      <= n_den;
        r_dur_zero <= n_dur_zero;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_qcnt     <= n_qcnt;
        if (out_load) begin
            r_out_frame    <= r_position[FNUM_W-1:0];
            r_out_playing  <= r_run;
            r_out_paused   <= r_hold;
            r_out_finished <= r_done;
            r_out_progress <= r_quo;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_frame_index = r_out_frame;
    assign o_playing     = r_out_playing;
    assign o_paused      = r_out_paused;
    assign o_finished    = r_out_finished;
    assign o_progress    = r_out_progress;

endmodule
